// File: rtl/core/sha256_message_hasher_unit_assert.svh
// assertion macros for the hasher
`ifndef SHA256_MESSAGE_HASHER_UNIT_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_UNIT_ASSERT_SVH

// implication checked every clock outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/sha_pkg.sv
package sha_pkg;

    localparam int QUEUE_DEPTH = 4;

    // front-to-back request: data byte or finish
    typedef struct packed {
        logic       fin;
        logic [7:0] data;
    } t_req;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[idx];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: rtl/core/sha_front.sv
module sha_front #(
    parameter int QDEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_kind,
    input  logic [7:0]    i_data_byte,
    output logic          o_q_valid,
    input  logic          i_q_ready,
    output sha_pkg::t_req o_q_req
);
    import sha_pkg::*;
    `include "sha256_message_hasher_unit_assert.svh"

    // depth must be a power of two so the pointers wrap on their own; the block itself does not enforce it
    localparam int AW = $clog2(QDEPTH);

    t_req          r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready   = (r_cnt != (AW+1)'(QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_req   = r_mem[r_rp];

    // classify and store the request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp].fin  <= i_kind;
            r_mem[r_wp].data <= i_data_byte;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + AW'(1);
            if (pop)  r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    `SHA_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(QDEPTH))
    `SHA_ASSERT_NXT(a_push_only, i_clk, i_rst_n, push && !pop, r_cnt != '0)
    `SHA_ASSERT_IMP(a_empty_nopop, i_clk, i_rst_n, r_cnt == '0, !pop)
endmodule

// File: rtl/core/sha_back.sv
module sha_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  sha_pkg::t_req i_q_req,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_digest_word,
    output logic [2:0]    o_word_index,
    output logic          o_last_word
);
    import sha_pkg::*;
    `include "sha256_message_hasher_unit_assert.svh"

    typedef enum logic [2:0] {S_IN, S_ROUND, S_ADD, S_EMIT} t_state;

    t_state        r_state;
    logic [60:0]   r_count;
    logic [255:0]  r_hash, r_v;
    logic [31:0]   r_w [16];  // block words: filled a byte at a time, then the schedule
    logic [5:0]    r_rnd;
    logic [5:0]    r_pos;
    logic          r_pad;    // finishing: padding in progress
    logic          r_extra;  // second pad block still to do
    logic [63:0]   r_bits;
    logic [2:0]    r_oi;

    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wn, s0, s1;
    logic [7:0]  pb;
    logic [4:0]  lane;

    assign o_q_ready = (r_state == S_IN) && !r_pad;
    assign {a, b, c, d, e, f, g, h} = r_v;

    // big-endian byte lane of the current position within its word
    assign lane = {~r_pos[1:0], 3'b000};

    // round logic and schedule
    always_comb begin
        s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        wn = s1 + r_w[9] + s0 + r_w[0];
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + round_k(r_rnd) + r_w[0];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    end

    // padding byte at the current position
    always_comb begin
        if (r_extra || r_pos < 6'd56) pb = 8'h00;
        else pb = 8'(r_bits >> (8 * (63 - int'(r_pos))));
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN; r_hash <= INIT_HASH; r_count <= '0;
            r_pad <= 1'b0; r_extra <= 1'b0; r_pos <= '0; o_valid <= 1'b0;
            r_oi <= '0;
        end else begin
            case (r_state)
                S_IN: begin
                    if (r_pad) begin
                        r_w[r_pos[5:2]][lane +: 8] <= pb;
                        r_pos <= r_pos + 6'd1;
                        if (r_pos == 6'd63) begin
                            r_state <= S_ROUND;
                        end
                    end else if (i_q_valid) begin
                        if (!i_q_req.fin) begin
                            r_w[r_pos[5:2]][lane +: 8] <= i_q_req.data;
                            r_count <= r_count + 61'd1;
                            r_pos <= r_pos + 6'd1;
                            if (r_pos == 6'd63) r_state <= S_ROUND;
                        end else begin
                            r_w[r_pos[5:2]][lane +: 8] <= 8'h80;
                            r_bits <= {r_count, 3'b000};
                            r_pad <= 1'b1;
                            r_extra <= (r_pos > 6'd55);
                            r_pos <= r_pos + 6'd1;
                            if (r_pos == 6'd63) r_state <= S_ROUND;
                        end
                    end
                    r_rnd <= '0;
                    r_v <= r_hash;
                end
                S_ROUND: begin
                    r_v <= {t1 + t2, a, b, c, d + t1, e, f, g};
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wn;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++)
                        r_hash[32*i +: 32] <= r_hash[32*i +: 32] + r_v[32*i +: 32];
                    if (r_pad && !r_extra) begin
                        r_state <= S_EMIT; o_valid <= 1'b1; r_oi <= '0;
                    end else begin
                        r_state <= S_IN; r_extra <= 1'b0;
                    end
                end
                S_EMIT: begin
                    if (i_ready) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            o_valid <= 1'b0; r_state <= S_IN; r_pad <= 1'b0;
                            r_hash <= INIT_HASH; r_count <= '0; r_pos <= '0;
                        end
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    assign o_digest_word = r_hash[32*(7-int'(r_oi)) +: 32];
    assign o_word_index  = r_oi;
    assign o_last_word   = (r_oi == 3'd7);

    `SHA_ASSERT_IMP(a_valid_emit, i_clk, i_rst_n, o_valid, r_state == S_EMIT)
    `SHA_ASSERT_IMP(a_noq_busy, i_clk, i_rst_n, o_q_ready, !o_valid)
    `SHA_ASSERT_NXT(a_last_done, i_clk, i_rst_n, o_valid && i_ready && o_last_word, !o_valid)
endmodule

// File: rtl/core/sha256_message_hasher_unit.sv
// channel | valid   | ready   | payload
// input   | i_valid | o_ready | i_kind, i_data_byte
// output  | o_valid | i_ready | o_digest_word, o_word_index, o_last_word
// the back end buffers data bytes and takes none while a full block is compressed
// (64 rounds of the single round unit and a feed-forward add)
// finish pads one byte per cycle to the block end, then one or two compressions
// a small request queue takes bytes while the back end compresses
// synchronous active-low reset restores the initial hash and empties the queue
module sha256_message_hasher_unit #(
    parameter int QDEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    logic q_valid, q_ready;
    t_req q_req;

    // accept and queue requests
    sha_front #(.QDEPTH(QDEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_data_byte,
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_req(q_req));

    // buffer, compress and emit
    sha_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_req(q_req),
        .o_valid, .i_ready, .o_digest_word, .o_word_index, .o_last_word);
endmodule

// File: sim/tb_sha256_message_hasher_unit.sv
// digest scoreboard: holds a sha-256 predictor and the queue of expected digest words
class digest_scoreboard;
    logic [31:0] hash_st [8];
    logic [7:0]  blk [64];
    logic [60:0] nbytes;
    logic [31:0] exp_word [$];
    logic [2:0]  exp_idx [$];
    logic        exp_last [$];
    int          mismatches;

    function new();
        restart();
        mismatches = 0;
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) hash_st[i] = sha_pkg::INIT_HASH[255 - 32*i -: 32];
        nbytes = '0;
    endfunction

    function logic [31:0] rr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of the block buffer
    function void compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        logic [31:0] k [64];
        k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[i] + w[i];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
    endfunction

    // note an accepted request
    function void note_request(logic kind, logic [7:0] b);
        int pos;
        logic [63:0] bits;
        pos = nbytes[5:0];
        if (!kind) begin
            blk[pos] = b;
            nbytes = nbytes + 1;
            if (pos == 63) compress();
            return;
        end
        bits = {nbytes, 3'b000};
        blk[pos] = 8'h80;
        pos++;
        if (pos > 56) begin
            for (int i = pos; i < 64; i++) blk[i] = 8'h00;
            compress();
            pos = 0;
        end
        for (int i = pos; i < 56; i++) blk[i] = 8'h00;
        for (int i = 0; i < 8; i++) blk[56+i] = bits[63 - 8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
            exp_word.push_back(hash_st[i]);
            exp_idx.push_back(i[2:0]);
            exp_last.push_back(i == 7);
        end
        restart();
    endfunction

    // check one accepted digest word
    function void check_word(logic [31:0] w, logic [2:0] idx, logic last);
        logic [31:0] ew;
        logic [2:0]  ei;
        logic        el;
        if (exp_word.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected digest word %h idx %0d", w, idx);
            return;
        end
        ew = exp_word.pop_front();
        ei = exp_idx.pop_front();
        el = exp_last.pop_front();
        if (w !== ew || idx !== ei || last !== el) begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                         ew, ei, el, w, idx, last);
        end
    endfunction
endclass

module tb_sha256_message_hasher_unit;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    digest_scoreboard sb = new();
    bit stim_done = 0;
    int burst_mode = 0;

    sha256_message_hasher_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // send one request, with a random gap before it unless in burst mode
    task automatic send_request(logic kind, logic [7:0] b);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(kind, b);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_request(1'b0, 8'($urandom_range(0, 255)));
        send_request(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // output side: random stalls per word, none in burst mode
    initial begin
        int stall;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check_word(o_digest_word, o_word_index, o_last_word);
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, fixed bytes, padding boundaries
        send_request(1'b1, 8'hff);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hff);
        send_request(1'b0, 8'h61);
        send_request(1'b1, 8'h00);
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        // random messages, mostly short, a few spanning blocks
        for (int m = 0; m < 4; m++) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) send_message($urandom_range(50, 130));
            else send_message($urandom_range(0, 20));
        end
        i_valid <= 1'b0;
        burst_mode = 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.exp_word.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb_sha256_message_hasher_unit: clean");
        end else begin
            $display("tb_sha256_message_hasher_unit: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_sha256_message_hasher_unit: errors");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_front.sv
rtl/core/sha_back.sv
rtl/core/sha256_message_hasher_unit.sv
sim/tb_sha256_message_hasher_unit.sv
